/* design/pcfm_pkg.sv */
// shared types, tables and constants for the pitch cv to fm note register writer
`default_nettype none

package pcfm_pkg;

   // field widths
   localparam int VOICE_W = 3;
   localparam int CV_W    = 17;
   localparam int FRAC_W  = 12;
   localparam int OCT_W   = CV_W - FRAC_W;
   localparam int MANT_W  = 31;
   localparam int FREQ_W  = 27;
   localparam int SHF_W   = 32;
   localparam int REM_W   = 23;
   localparam int DIV_W   = 13;
   localparam int FNUM_W  = 10;
   localparam int BLK_W   = 3;
   localparam int CH_W    = 4;
   localparam int ADDR_W  = 9;
   localparam int DATA_W  = 8;
   localparam int BLOCKS  = 8;
   localparam int CHANNEL_VOICES = 6;

   // 1.0 in q30
   localparam logic [MANT_W-1:0] MANT_ONE = 31'h4000_0000;

   // middle c in millihertz with 8 fraction bits, multiplied by the q30 mantissa
   localparam logic [25:0] FREQ_C = 26'd66976154;

   // highest octave number that can still land in a block
   localparam logic signed [OCT_W-1:0] OCT_MAX = 5'sd4;

   // 2^(2^b/4096) in q30 for each fraction bit b
   localparam logic [MANT_W-1:0] EXP2_Q30 [FRAC_W] = '{
      31'd1073923544, 31'd1074105295, 31'd1074468887, 31'd1075196444,
      31'd1076653033, 31'd1079572136, 31'd1085434106, 31'd1097253708,
      31'd1121280436, 31'd1170923762, 31'd1276901417, 31'd1518500250
   };

   // upper limit of each octave block in mhz
   localparam logic [REM_W-1:0] BLOCK_TOP [BLOCKS] = '{
      23'd48503, 23'd97006, 23'd194013, 23'd388026,
      23'd776053, 23'd1552107, 23'd3104215, 23'd6208431
   };

   // frequency step of each octave block in mhz
   localparam logic [DIV_W-1:0] BLOCK_STEP [BLOCKS] = '{
      13'd48, 13'd95, 13'd190, 13'd379, 13'd759, 13'd1517, 13'd3034, 13'd6069
   };

   // primary hardware channel of each voice, the paired channel sits three above
   localparam logic [CH_W-1:0] PRIMARY_CH [CHANNEL_VOICES] = '{
      4'd0, 4'd1, 4'd2, 4'd9, 4'd10, 4'd11
   };
   localparam logic [CH_W-1:0] PAIR_STEP = 4'd3;

   // register map
   localparam logic [ADDR_W-1:0] LO_BASE     = 9'h0A0;
   localparam logic [ADDR_W-1:0] HI_BASE     = 9'h0B0;
   localparam logic [ADDR_W-1:0] BANK_OFFSET = 9'h100;
   localparam logic [CH_W-1:0]   BANK_SPLIT  = 4'd9;

   // gate threshold after reset, one volt
   localparam logic signed [CV_W-1:0] GATE_RESET = 17'sd4096;

   // what travels alongside the mantissa pipeline
   typedef struct packed {
      logic [VOICE_W-1:0] voice;
      logic [OCT_W-1:0]   octave;
      logic               gate_on;
   } side_type;

   // what travels alongside the divider pipeline
   typedef struct packed {
      logic [VOICE_W-1:0] voice;
      logic [BLK_W-1:0]   blk;
      logic               key;
   } tag_type;

   // finished note for the write sequencer
   typedef struct packed {
      logic [VOICE_W-1:0] voice;
      logic [BLK_W-1:0]   blk;
      logic               key;
      logic [FNUM_W-1:0]  fnum;
   } note_type;

   // channel number to register offset, upper channels live in the second bank
   function automatic logic [ADDR_W-1:0] chan_offset(input logic [CH_W-1:0] ch);
      logic [ADDR_W-1:0] wide;
      wide = {{(ADDR_W-CH_W){1'b0}}, ch};
      if (ch < BANK_SPLIT) begin
         chan_offset = wide;
      end else begin
         chan_offset = wide + BANK_OFFSET - {{(ADDR_W-CH_W){1'b0}}, BANK_SPLIT};
      end
   endfunction

endpackage

`default_nettype wire

/* design/pcfm_exp2.sv */
// exp2 of the pitch fraction, one multiply per stage, then scaling to middle c
`default_nettype none

module pcfm_exp2 (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          adv,
   input  wire logic                          in_valid,
   input  wire pcfm_pkg::side_type            in_side,
   input  wire logic [pcfm_pkg::FRAC_W-1:0]   in_frac,
   output logic                               out_valid,
   output pcfm_pkg::side_type                 out_side,
   output logic [pcfm_pkg::FREQ_W-1:0]        out_freq
);

   localparam int STAGES = pcfm_pkg::FRAC_W;
   localparam int MW     = pcfm_pkg::MANT_W;

   logic                         chain_valid [STAGES+1];
   pcfm_pkg::side_type           chain_side  [STAGES+1];
   logic [pcfm_pkg::FRAC_W-1:0]  chain_frac  [STAGES+1];
   logic [MW-1:0]                chain_mant  [STAGES+1];

   assign chain_valid[0] = in_valid;
   assign chain_side[0]  = in_side;
   assign chain_frac[0]  = in_frac;
   assign chain_mant[0]  = pcfm_pkg::MANT_ONE;

   // one fraction bit per stage, top bit first
   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      localparam int BIT = STAGES - 1 - i;
      logic [2*MW-1:0]              prod;
      logic [MW-1:0]                mant_in;
      logic                         valid_ff;
      pcfm_pkg::side_type           side_ff;
      logic [pcfm_pkg::FRAC_W-1:0]  frac_ff;
      logic [MW-1:0]                mant_ff;

      assign prod    = {{MW{1'b0}}, chain_mant[i]} * {{MW{1'b0}}, pcfm_pkg::EXP2_Q30[BIT]};
      assign mant_in = chain_frac[i][BIT] ? prod[2*MW-2:MW-1] : chain_mant[i];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (adv) begin
            valid_ff <= chain_valid[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff <= chain_side[i];
            frac_ff <= chain_frac[i];
            mant_ff <= mant_in;
         end
      end

      assign chain_valid[i+1] = valid_ff;
      assign chain_side[i+1]  = side_ff;
      assign chain_frac[i+1]  = frac_ff;
      assign chain_mant[i+1]  = mant_ff;
   end

   // frequency at octave zero, mhz with 8 fraction bits
   logic [MW+25:0]                fprod;
   logic [pcfm_pkg::FREQ_W-1:0]   freq_in;
   logic                          fin_valid_ff;
   pcfm_pkg::side_type            fin_side_ff;
   logic [pcfm_pkg::FREQ_W-1:0]   freq_ff;

   assign fprod   = {26'b0, chain_mant[STAGES]} * {{MW{1'b0}}, pcfm_pkg::FREQ_C};
   assign freq_in = fprod[pcfm_pkg::FREQ_W+29:30];

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (adv) begin
         fin_valid_ff <= chain_valid[STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fin_side_ff <= chain_side[STAGES];
         freq_ff     <= freq_in;
      end
   end

   assign out_valid = fin_valid_ff;
   assign out_side  = fin_side_ff;
   assign out_freq  = freq_ff;

endmodule

`default_nettype wire

/* design/pcfm_divide.sv */
// restoring divider by the block step, one quotient bit per stage
`default_nettype none

module pcfm_divide (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          adv,
   input  wire logic                          in_valid,
   input  wire pcfm_pkg::tag_type             in_tag,
   input  wire logic [pcfm_pkg::REM_W-1:0]    in_rem,
   input  wire logic [pcfm_pkg::DIV_W-1:0]    in_div,
   output logic                               out_valid,
   output pcfm_pkg::note_type                 out_note
);

   localparam int QW = pcfm_pkg::FNUM_W;
   localparam int RW = pcfm_pkg::REM_W;
   localparam int DW = pcfm_pkg::DIV_W;

   logic                 chain_valid [QW+1];
   pcfm_pkg::tag_type    chain_tag   [QW+1];
   logic [RW-1:0]        chain_rem   [QW+1];
   logic [DW-1:0]        chain_div   [QW+1];
   logic [QW-1:0]        chain_quo   [QW+1];

   assign chain_valid[0] = in_valid;
   assign chain_tag[0]   = in_tag;
   assign chain_rem[0]   = in_rem;
   assign chain_div[0]   = in_div;
   assign chain_quo[0]   = '0;

   // quotient msb first
   for (genvar i = 0; i < QW; i++) begin : g_stage
      localparam int SH = QW - 1 - i;
      logic [RW-1:0]      trial;
      logic               hit;
      logic [RW-1:0]      rem_in;
      logic [QW-1:0]      quo_in;
      logic               valid_ff;
      pcfm_pkg::tag_type  tag_ff;
      logic [RW-1:0]      rem_ff;
      logic [DW-1:0]      div_ff;
      logic [QW-1:0]      quo_ff;

      always_comb begin
         trial      = {{(RW-DW){1'b0}}, chain_div[i]} << SH;
         hit        = chain_rem[i] >= trial;
         rem_in     = hit ? chain_rem[i] - trial : chain_rem[i];
         quo_in     = chain_quo[i];
         quo_in[SH] = hit;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (adv) begin
            valid_ff <= chain_valid[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            tag_ff <= chain_tag[i];
            rem_ff <= rem_in;
            div_ff <= chain_div[i];
            quo_ff <= quo_in;
         end
      end

      assign chain_valid[i+1] = valid_ff;
      assign chain_tag[i+1]   = tag_ff;
      assign chain_rem[i+1]   = rem_ff;
      assign chain_div[i+1]   = div_ff;
      assign chain_quo[i+1]   = quo_ff;
   end

   assign out_valid      = chain_valid[QW];
   assign out_note.voice = chain_tag[QW].voice;
   assign out_note.blk   = chain_tag[QW].blk;
   assign out_note.key   = chain_tag[QW].key;
   assign out_note.fnum  = chain_quo[QW];

endmodule

`default_nettype wire

/* design/pcfm_serial.sv */
// turns one note into its four register write beats
`default_nettype none

module pcfm_serial (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire pcfm_pkg::note_type            in_note,
   output logic                               take,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic [pcfm_pkg::ADDR_W-1:0]        out_reg_address,
   output logic [pcfm_pkg::DATA_W-1:0]        out_reg_data,
   output logic                               out_last_write
);

   localparam logic [1:0] BEAT_LO_PRI = 2'd0;
   localparam logic [1:0] BEAT_LO_PAR = 2'd1;
   localparam logic [1:0] BEAT_HI_PRI = 2'd2;
   localparam logic [1:0] BEAT_HI_PAR = 2'd3;

   logic                            busy_ff;
   logic [1:0]                      beat_ff;
   logic [pcfm_pkg::ADDR_W-1:0]     pri_off_ff;
   logic [pcfm_pkg::ADDR_W-1:0]     par_off_ff;
   logic [pcfm_pkg::DATA_W-1:0]     lo_ff;
   logic [pcfm_pkg::DATA_W-1:0]     hi_ff;
   logic [pcfm_pkg::CH_W-1:0]       pri_ch;

   // free, or handing over the last beat this cycle
   assign take = !busy_ff || (out_ready && beat_ff == BEAT_HI_PAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         beat_ff <= BEAT_LO_PRI;
      end else if (take) begin
         busy_ff <= in_valid;
         beat_ff <= BEAT_LO_PRI;
      end else if (out_ready) begin
         beat_ff <= beat_ff + 2'd1;
      end
   end

   // note bytes and channel offsets
   assign pri_ch = pcfm_pkg::PRIMARY_CH[in_note.voice];

   always_ff @(posedge clock) begin
      if (take && in_valid) begin
         pri_off_ff <= pcfm_pkg::chan_offset(pri_ch);
         par_off_ff <= pcfm_pkg::chan_offset(pri_ch + pcfm_pkg::PAIR_STEP);
         lo_ff      <= in_note.fnum[pcfm_pkg::DATA_W-1:0];
         hi_ff      <= {2'b00, in_note.key, in_note.blk,
                        in_note.fnum[pcfm_pkg::FNUM_W-1:pcfm_pkg::DATA_W]};
      end
   end

   // beat payload
   always_comb begin
      out_last_write = 1'b0;
      case (beat_ff)
         BEAT_LO_PRI: begin
            out_reg_address = pcfm_pkg::LO_BASE + pri_off_ff;
            out_reg_data    = lo_ff;
         end
         BEAT_LO_PAR: begin
            out_reg_address = pcfm_pkg::LO_BASE + par_off_ff;
            out_reg_data    = lo_ff;
         end
         BEAT_HI_PRI: begin
            out_reg_address = pcfm_pkg::HI_BASE + pri_off_ff;
            out_reg_data    = hi_ff;
         end
         BEAT_HI_PAR: begin
            out_reg_address = pcfm_pkg::HI_BASE + par_off_ff;
            out_reg_data    = hi_ff;
            out_last_write  = 1'b1;
         end
         default: begin
            out_reg_address = pcfm_pkg::LO_BASE + pri_off_ff;
            out_reg_data    = lo_ff;
         end
      endcase
   end

   assign out_valid = busy_ff;

endmodule

`default_nettype wire

/* design/pitch_cv_to_fm_note_register_writes_top.sv */
// the first write beat is valid after the entry, exp2, octave shift, block search and divider
// stages and the sequencer registers, the other three following while ready stays high
// throughput: one item per cycle through the pipeline while it does not stall, one write beat
// per cycle at the output while ready is high; each note needs four beats on the result port;
// the whole pipeline stalls as one while a finished note waits for the sequencer's last beat
// reset: synchronous, clears all valid bits and the beat counter, threshold returns to one volt
`default_nettype none

module pitch_cv_to_fm_note_register_writes_top #(
   parameter int VOICES = 6
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic signed [16:0]              csr_gate_threshold,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [2:0]                      req_voice,
   input  wire logic signed [16:0]              req_pitch_cv,
   input  wire logic signed [16:0]              req_gate_cv,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [8:0]                           rsp_reg_address,
   output logic [7:0]                           rsp_reg_data,
   output logic                                 rsp_last_write
);

   localparam int FW = pcfm_pkg::FREQ_W;
   localparam int SW = pcfm_pkg::SHF_W;
   localparam int RW = pcfm_pkg::REM_W;

   logic                                  adv;
   logic                                  tail_valid;
   logic                                  take;

   // gate threshold register
   logic signed [pcfm_pkg::CV_W-1:0]      thresh_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= pcfm_pkg::GATE_RESET;
      end else if (csr_valid) begin
         thresh_ff <= csr_gate_threshold;
      end
   end

   // whole pipeline moves unless the tail holds a note the sequencer cannot take
   assign adv       = !tail_valid || take;
   assign req_ready = adv;

   // entry stage: split pitch, compare gate, drop voices that do not exist
   logic                            e_valid_in;
   pcfm_pkg::side_type              e_side_in;
   logic                            e_valid_ff;
   pcfm_pkg::side_type              e_side_ff;
   logic [pcfm_pkg::FRAC_W-1:0]     e_frac_ff;

   always_comb begin
      e_valid_in        = req_valid && (req_voice < 3'(VOICES));
      e_side_in.voice   = req_voice;
      e_side_in.octave  = req_pitch_cv[pcfm_pkg::CV_W-1:pcfm_pkg::FRAC_W];
      e_side_in.gate_on = req_gate_cv > thresh_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (adv) begin
         e_valid_ff <= e_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_side_ff <= e_side_in;
         e_frac_ff <= req_pitch_cv[pcfm_pkg::FRAC_W-1:0];
      end
   end

   // mantissa and base frequency
   logic                            x_valid;
   pcfm_pkg::side_type              x_side;
   logic [FW-1:0]                   x_freq;

   pcfm_exp2 u_exp2 (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (e_valid_ff),
      .in_side   (e_side_ff),
      .in_frac   (e_frac_ff),
      .out_valid (x_valid),
      .out_side  (x_side),
      .out_freq  (x_freq)
   );

   // octave shift stage
   logic signed [pcfm_pkg::OCT_W-1:0]     octave;
   logic [pcfm_pkg::OCT_W-1:0]            neg_oct;
   logic [SW-1:0]                         s_freq_in;
   logic                                  s_valid_ff;
   pcfm_pkg::side_type                    s_side_ff;
   logic [SW-1:0]                         s_freq_ff;
   logic                                  s_ok_ff;

   always_comb begin
      octave  = $signed(x_side.octave);
      neg_oct = ~x_side.octave + 5'd1;
      if (!octave[pcfm_pkg::OCT_W-1]) begin
         s_freq_in = {{(SW-FW){1'b0}}, x_freq} << x_side.octave[2:0];
      end else begin
         s_freq_in = {{(SW-FW){1'b0}}, x_freq} >> neg_oct;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else if (adv) begin
         s_valid_ff <= x_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s_side_ff <= x_side;
         s_freq_ff <= s_freq_in;
         s_ok_ff   <= octave <= pcfm_pkg::OCT_MAX;
      end
   end

   // block search stage, out of range notes get a zero dividend
   logic                                  found;
   logic                                  in_range;
   logic [pcfm_pkg::BLK_W-1:0]            blk;
   pcfm_pkg::tag_type                     b_tag_in;
   logic                                  b_valid_ff;
   pcfm_pkg::tag_type                     b_tag_ff;
   logic [RW-1:0]                         b_rem_ff;
   logic [pcfm_pkg::DIV_W-1:0]            b_div_ff;

   always_comb begin
      found = 1'b0;
      blk   = '0;
      for (int b = pcfm_pkg::BLOCKS - 1; b >= 0; b--) begin
         if (s_freq_ff < {1'b0, pcfm_pkg::BLOCK_TOP[b], 8'h00}) begin
            found = 1'b1;
            blk   = pcfm_pkg::BLK_W'(b);
         end
      end
      in_range       = found && s_ok_ff;
      b_tag_in.voice = s_side_ff.voice;
      b_tag_in.blk   = in_range ? blk : '0;
      b_tag_in.key   = in_range && s_side_ff.gate_on;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= s_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_tag_ff <= b_tag_in;
         b_rem_ff <= in_range ? s_freq_ff[RW+7:8] : '0;
         b_div_ff <= pcfm_pkg::BLOCK_STEP[b_tag_in.blk];
      end
   end

   // frequency number
   pcfm_pkg::note_type                    d_note;

   pcfm_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (b_valid_ff),
      .in_tag    (b_tag_ff),
      .in_rem    (b_rem_ff),
      .in_div    (b_div_ff),
      .out_valid (tail_valid),
      .out_note  (d_note)
   );

   // register write beats
   pcfm_serial u_serial (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (tail_valid),
      .in_note         (d_note),
      .take            (take),
      .out_valid       (rsp_valid),
      .out_ready       (rsp_ready),
      .out_reg_address (rsp_reg_address),
      .out_reg_data    (rsp_reg_data),
      .out_last_write  (rsp_last_write)
   );

`ifndef ASSERT_OFF
   // input stalls only while an unfinished write beat sits at the output
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !(rsp_ready && rsp_last_write)))
      else $error("input stalled without a blocked write beat");

   // the four writes of one note come without a gap
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_write) |=> rsp_valid)
      else $error("write sequence broken before its last beat");

   // reset leaves no beat pending
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("write beat valid right after reset");
`endif

endmodule

`default_nettype wire
